@@ rtl/pgl_pkg.sv @@
// pgl_pkg: shared types and constants of the pgn token lexer
// byte class flags, queue entry, lexer mode and token kind codes
// no dependencies
package pgl_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PLUS   = 8'h2B;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_QUOTED  = 3'd1,
		MODE_ESCAPE  = 3'd2,
		MODE_COMMENT = 3'd3,
		MODE_WORD    = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		KIND_SPACE   = 3'd0,
		KIND_QUOTED  = 3'd1,
		KIND_COMMENT = 3'd2,
		KIND_WORD    = 3'd3,
		KIND_SINGLE  = 3'd4
	} kind_t;

	typedef struct packed {
		logic is_space;
		logic is_quote;
		logic is_semi;
		logic is_bslash;
		logic is_eol;
		logic starts_word;
		logic cont_word;
	} class_t;

	typedef struct packed {
		logic [7:0] text;
		logic       last;
		class_t     cls;
	} entry_t;

endpackage

@@ rtl/pgl_front.sv @@
// pgl_front: input stage of the pgn token lexer
// takes one text byte per word, classifies it and hands it to the queue
// depends on pgl_pkg
module pgl_front import pgl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] text_byte,
	input  logic       stream_end,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       q_full,
	output logic       push,
	output entry_t     ent_s1
);

	logic   valid_s1;
	logic   load;
	class_t cls;

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
		       (c >= 8'h61 && c <= 8'h7A);
	endfunction

	always_comb begin
		cls.is_space    = (text_byte == CH_SPACE) ||
		                  (text_byte >= CH_TAB && text_byte <= CH_CR);
		cls.is_quote    = (text_byte == CH_QUOTE);
		cls.is_semi     = (text_byte == CH_SEMI);
		cls.is_bslash   = (text_byte == CH_BSLASH);
		cls.is_eol      = (text_byte == CH_LF) || (text_byte == CH_CR);
		cls.starts_word = is_alnum(text_byte) || (text_byte == CH_MINUS) ||
		                  (text_byte == CH_PLUS) || (text_byte == CH_UNDER);
		// '$' is deliberately absent from both word sets
		cls.cont_word   = cls.starts_word || (text_byte == CH_DOT) ||
		                  (text_byte == CH_HASH) || (text_byte == CH_EQUAL);
	end

	assign in_stall = valid_s1 && q_full;
	assign load     = in_valid && !in_stall;
	assign push     = valid_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_s1.text <= text_byte;
			ent_s1.last <= stream_end;
			ent_s1.cls  <= cls;
		end
	end

endmodule

@@ rtl/pgl_queue.sv @@
// pgl_queue: small queue of classified bytes between front and back
// register array with read and write pointers and a fill count
// depends on pgl_pkg
module pgl_queue import pgl_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_ent,
	output logic   full,
	input  logic   pop,
	output logic   q_valid,
	output entry_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full    = (count_q == CNT_W'(DEPTH));
	assign q_valid = (count_q != '0);
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_ent;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");

	a_no_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");

	a_no_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> !full)
		else $error("push into full queue");

endmodule

@@ rtl/pgl_back.sv @@
// pgl_back: lexer mode machine and output register of the pgn token lexer
// pops classified bytes from the queue and labels them
// depends on pgl_pkg
module pgl_back import pgl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  entry_t     head,
	output logic       pop,
	output logic [7:0] byte_out,
	output logic [2:0] token_kind,
	output logic       token_begin,
	output logic       end_out,
	output logic       out_valid,
	input  logic       out_stall
);

	mode_t      mode_q;
	mode_t      mode_next;
	kind_t      kind;
	logic       begin_tok;
	logic       valid_q;
	logic [7:0] byte_q;
	kind_t      kind_q;
	logic       begin_q;
	logic       end_q;

	// a byte seen between tokens
	function automatic kind_t idle_kind(input class_t c);
		priority if (c.is_space)    return KIND_SPACE;
		else if (c.is_quote)        return KIND_QUOTED;
		else if (c.is_semi)         return KIND_COMMENT;
		else if (c.starts_word)     return KIND_WORD;
		else                        return KIND_SINGLE;
	endfunction

	function automatic mode_t idle_mode(input class_t c);
		priority if (c.is_space)    return MODE_IDLE;
		else if (c.is_quote)        return MODE_QUOTED;
		else if (c.is_semi)         return MODE_COMMENT;
		else if (c.starts_word)     return MODE_WORD;
		else                        return MODE_IDLE;
	endfunction

	assign pop = q_valid && (!valid_q || !out_stall);

	// next state
	always_comb begin
		mode_next = MODE_IDLE;
		unique case (mode_q)
			MODE_QUOTED: begin
				priority if (head.cls.is_bslash) mode_next = MODE_ESCAPE;
				else if (head.cls.is_quote)      mode_next = MODE_IDLE;
				else                             mode_next = MODE_QUOTED;
			end
			MODE_ESCAPE: mode_next = MODE_QUOTED;
			MODE_COMMENT: begin
				mode_next = head.cls.is_eol ? MODE_IDLE : MODE_COMMENT;
			end
			MODE_WORD: begin
				mode_next = head.cls.cont_word ? MODE_WORD : idle_mode(head.cls);
			end
			default: mode_next = idle_mode(head.cls);
		endcase
		// end of text drops any open token
		if (head.last) begin
			mode_next = MODE_IDLE;
		end
	end

	// outputs
	always_comb begin
		kind      = KIND_SPACE;
		begin_tok = 1'b0;
		unique case (mode_q)
			MODE_QUOTED, MODE_ESCAPE: kind = KIND_QUOTED;
			MODE_COMMENT: kind = head.cls.is_eol ? KIND_SPACE : KIND_COMMENT;
			MODE_WORD: begin
				if (head.cls.cont_word) begin
					kind = KIND_WORD;
				end else begin
					kind      = idle_kind(head.cls);
					begin_tok = !head.cls.is_space;
				end
			end
			default: begin
				kind      = idle_kind(head.cls);
				begin_tok = !head.cls.is_space;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q  <= mode_next;
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			byte_q  <= head.text;
			kind_q  <= kind;
			begin_q <= begin_tok;
			end_q   <= head.last;
		end
	end

	assign byte_out    = byte_q;
	assign token_kind  = kind_q;
	assign token_begin = begin_q;
	assign end_out     = end_q;
	assign out_valid   = valid_q;

	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.last |=> mode_q == MODE_IDLE)
		else $error("mode not idle after end of text");

	a_escape_quoted: assert property (@(posedge clk) disable iff (!arst_n)
		pop && mode_q == MODE_ESCAPE |=> kind_q == KIND_QUOTED && !begin_q)
		else $error("escaped byte left the string");

	a_begin_not_space: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && begin_q |-> kind_q != KIND_SPACE)
		else $error("token start labeled as space");

endmodule

@@ rtl/pgn_token_lexer.sv @@
// pgn_token_lexer: top level, byte-serial pgn text tokenizer
// front classifier, queue and mode/output back end
// depends on pgl_pkg, pgl_front, pgl_queue, pgl_back
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  input   | in_valid / in_stall  | text_byte, stream_end
//  output  | out_valid / out_stall| byte_out, token_kind, token_begin, end_out
//
// one word per cycle sustained while out_stall is low; mode loop is just mode_q
// each byte passes the front register, a queue slot, then the output register
// reset clears the lexer mode to idle and empties front, queue and output
// out_stall holds the output register, then fills the queue (DEPTH words)
// in_stall rises only when the front register holds a word and the queue is full
module pgn_token_lexer import pgl_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] text_byte,
	input  logic       stream_end,
	input  logic       in_valid,
	output logic       in_stall,
	output logic [7:0] byte_out,
	output logic [2:0] token_kind,
	output logic       token_begin,
	output logic       end_out,
	output logic       out_valid,
	input  logic       out_stall
);

	logic   q_full;
	logic   push;
	entry_t ent_s1;
	logic   pop;
	logic   q_valid;
	entry_t head;

	pgl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_byte  (text_byte),
		.stream_end (stream_end),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.q_full     (q_full),
		.push       (push),
		.ent_s1     (ent_s1)
	);

	pgl_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (ent_s1),
		.full     (q_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.head     (head)
	);

	pgl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.head        (head),
		.pop         (pop),
		.byte_out    (byte_out),
		.token_kind  (token_kind),
		.token_begin (token_begin),
		.end_out     (end_out),
		.out_valid   (out_valid),
		.out_stall   (out_stall)
	);

endmodule

@@ tb/sv/pgn_token_lexer_tb.sv @@
// pgn_token_lexer_tb: self-checking bench for the byte-serial pgn token lexer
// drives pgn-like text through valid/stall, predicts each byte's label and compares
// depends on pgl_pkg and pgn_token_lexer
module pgn_token_lexer_tb;
	import pgl_pkg::*;

	localparam int HOLD_CYCLES = 200;
	localparam int QUIET_LIMIT = 2000;
	localparam int END_CYCLES  = 16;
	localparam logic [7:0] MARKS [8] = '{CH_DOT, CH_HASH, CH_EQUAL, CH_DOLLAR,
		"[", "]", "(", "*"};

	typedef enum int {PICK_ANY, PICK_HEAD, PICK_TAIL, PICK_BLANK, PICK_PLAIN, PICK_TEXT} pick_t;

	typedef struct {
		logic [7:0] text;
		kind_t      kind;
		logic       opens;
		logic       last;
	} label_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic [7:0] text_byte = 8'h00;
	logic       stream_end = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] byte_out;
	logic [2:0] token_kind;
	logic       token_begin;
	logic       end_out;
	logic       out_valid;
	logic       out_stall = 1'b0;

	mode_t  lex_mode = MODE_IDLE;
	label_t label_q[$];
	int     idle_pct = 0;
	int     stall_pct = 0;
	int     fail_count = 0;
	int     byte_count = 0;
	int     token_count = 0;
	int     end_count = 0;
	int     quiet_cycles = 0;
	int     hold_left = 0;
	bit     hold_req = 1'b0;

	always #5 clk = ~clk;

	pgn_token_lexer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.text_byte(text_byte),
		.stream_end(stream_end),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.byte_out(byte_out),
		.token_kind(token_kind),
		.token_begin(token_begin),
		.end_out(end_out),
		.out_valid(out_valid),
		.out_stall(out_stall)
	);

	function automatic bit is_blank(logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic bit is_alnum(logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic bit word_head(logic [7:0] c);
		return is_alnum(c) || c == CH_MINUS || c == CH_PLUS || c == CH_UNDER;
	endfunction

	function automatic bit word_tail(logic [7:0] c);
		return word_head(c) || c == CH_DOT || c == CH_HASH || c == CH_EQUAL;
	endfunction

	// byte seen between tokens: may open a new token
	function automatic void open_token(input logic [7:0] c, output kind_t kind,
			output logic opens);
		kind = KIND_SPACE;
		opens = 1'b0;
		lex_mode = MODE_IDLE;
		if (!is_blank(c)) begin
			opens = 1'b1;
			if (c == CH_QUOTE) begin
				kind = KIND_QUOTED;
				lex_mode = MODE_QUOTED;
			end else if (c == CH_SEMI) begin
				kind = KIND_COMMENT;
				lex_mode = MODE_COMMENT;
			end else if (word_head(c)) begin
				kind = KIND_WORD;
				lex_mode = MODE_WORD;
			end else begin
				kind = KIND_SINGLE;
			end
		end
	endfunction

	function automatic void label_byte(input logic [7:0] c, input logic last,
			output kind_t kind, output logic opens);
		kind = KIND_SPACE;
		opens = 1'b0;
		case (lex_mode)
		MODE_QUOTED: begin
			kind = KIND_QUOTED;
			if (c == CH_BSLASH)
				lex_mode = MODE_ESCAPE;
			else if (c == CH_QUOTE)
				lex_mode = MODE_IDLE;
		end
		MODE_ESCAPE: begin
			kind = KIND_QUOTED;
			lex_mode = MODE_QUOTED;
		end
		MODE_COMMENT: begin
			if (c == CH_LF || c == CH_CR)
				lex_mode = MODE_IDLE;
			else
				kind = KIND_COMMENT;
		end
		MODE_WORD: begin
			if (word_tail(c))
				kind = KIND_WORD;
			else
				open_token(c, kind, opens);
		end
		default: begin
			open_token(c, kind, opens);
		end
		endcase
		if (last)
			lex_mode = MODE_IDLE;
	endfunction

	function automatic logic [7:0] pick_byte(pick_t want);
		logic [7:0] c;
		bit         ok;
		do begin
			c = 8'($urandom_range(255));
			case (want)
			PICK_HEAD:  ok = word_head(c);
			PICK_TAIL:  ok = word_tail(c);
			PICK_BLANK: ok = is_blank(c);
			PICK_PLAIN: ok = c != CH_QUOTE && c != CH_BSLASH;
			PICK_TEXT:  ok = c != CH_CR && c != CH_LF;
			default:    ok = 1'b1;
			endcase
		end while (!ok);
		return c;
	endfunction

	// entered and left at a falling edge, so valid gets one assignment per step
	task automatic send_word(input logic [7:0] c, input logic last);
		label_t lab;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= c;
		stream_end <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		lab.text = c;
		lab.last = last;
		label_byte(c, last, lab.kind, lab.opens);
		label_q.push_back(lab);
		byte_count++;
		token_count += lab.opens;
		end_count += last;
		@(negedge clk);
	endtask

	task automatic send_noisy(input logic [7:0] c);
		send_word(c, $urandom_range(63) == 0);
	endtask

	task automatic send_text(input string s, input logic last_at_end);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], last_at_end && i == s.len() - 1);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (label_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// one pgn-like piece: mostly well formed, with noise and cut-off pieces mixed in
	task automatic send_fragment();
		int len;
		len = $urandom_range(6);
		case ($urandom_range(9))
		0, 1: begin
			send_noisy(pick_byte(PICK_HEAD));
			repeat (len) send_noisy(pick_byte(PICK_TAIL));
		end
		2: begin
			send_noisy(CH_QUOTE);
			repeat (len) begin
				if ($urandom_range(4) == 0) begin
					send_noisy(CH_BSLASH);
					send_noisy($urandom_range(2) == 0 ? CH_QUOTE : pick_byte(PICK_ANY));
				end else begin
					send_noisy(pick_byte(PICK_PLAIN));
				end
			end
			if ($urandom_range(9) != 0)
				send_noisy(CH_QUOTE);
		end
		3: begin
			send_noisy(CH_SEMI);
			repeat (len) send_noisy(pick_byte(PICK_TEXT));
			send_noisy($urandom_range(1) ? CH_CR : CH_LF);
		end
		4, 5: begin
			repeat ($urandom_range(1, 3)) send_noisy(pick_byte(PICK_BLANK));
		end
		6: begin
			send_noisy(MARKS[$urandom_range(7)]);
		end
		default: begin
			send_noisy(pick_byte(PICK_ANY));
		end
		endcase
	endtask

	task automatic test_directed();
		send_text("1.e4", 1'b0);
		send_word(CH_TAB, 1'b0);
		send_text("\"a\\\"b\"", 1'b0);
		send_text(";c", 1'b0);
		send_word(CH_CR, 1'b0);
		// lone marks, dollar, then a word opened by '-'
		send_text(".#=$-_+", 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'h00, 1'b0);
		send_text(";x", 1'b0);
		send_word(CH_LF, 1'b0);
		// text ends right after a backslash inside a string
		send_text("\"\\", 1'b1);
		send_text("Qa", 1'b1);
	endtask

	task automatic test_random(input int in_idle, input int out_idle, input int count);
		int stop;
		idle_pct = in_idle;
		stall_pct = out_idle;
		stop = byte_count + count;
		while (byte_count < stop)
			send_fragment();
	endtask

	task automatic test_long_stall();
		int stop;
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b1;
		stop = byte_count + 40;
		while (byte_count < stop)
			send_fragment();
		wait_drained();
	endtask

	task automatic test_pause_drain();
		int stop;
		idle_pct = 25;
		stall_pct = 25;
		repeat (3) begin
			stop = byte_count + 20;
			while (byte_count < stop)
				send_fragment();
			wait_drained();
		end
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		label_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (label_q.size() == 0) begin
				$error("byte_out: expected nothing, got %h", byte_out);
				fail_count++;
			end else begin
				want = label_q.pop_front();
				if (byte_out !== want.text) begin
					$error("byte_out: expected %h, got %h", want.text, byte_out);
					fail_count++;
				end
				if (token_kind !== want.kind) begin
					$error("token_kind: expected %0d, got %0d", want.kind, token_kind);
					fail_count++;
				end
				if (token_begin !== want.opens) begin
					$error("token_begin: expected %b, got %b", want.opens, token_begin);
					fail_count++;
				end
				if (end_out !== want.last) begin
					$error("end_out: expected %b, got %b", want.last, end_out);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("pgn_token_lexer_tb NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		wait_drained();
		test_random(0, 0, 450);
		test_random(57, 0, 450);
		test_random(0, 57, 450);
		test_random(25, 25, 450);
		test_long_stall();
		test_pause_drain();
		wait_drained();
		repeat (END_CYCLES) @(negedge clk);
		$display("lexed %0d bytes: %0d tokens opened, %0d text ends", byte_count,
			token_count, end_count);
		$display("mixes: free flow, input gaps, output stalls, both, long hold, drain pauses");
		if (fail_count == 0)
			$display("pgn_token_lexer_tb OK");
		else
			$display("pgn_token_lexer_tb NOT OK");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/pgl_pkg.sv
rtl/pgl_front.sv
rtl/pgl_queue.sv
rtl/pgl_back.sv
rtl/pgn_token_lexer.sv
tb/sv/pgn_token_lexer_tb.sv
